/* hw/rtl/fthb_pkg.sv */
// Package for the binary32 to half / bfloat16 narrowing block.
// Holds the operation codes and the format constants shared by the RTL files.
// No dependencies.
package fthb_pkg;

   // Operation codes carried on req_func
   typedef enum logic [2:0] {
      FUNC_RTNE_HALF = 3'd0,
      FUNC_RTNE_BF16 = 3'd1,
      FUNC_RTZ_HALF  = 3'd2,
      FUNC_RTZ_BF16  = 3'd3,
      FUNC_FAST_HALF = 3'd4,
      FUNC_FAST_BF16 = 3'd5
   } func_type;

   localparam int unsigned FUNC_WIDTH   = 3;
   localparam int unsigned SINGLE_WIDTH = 32;
   localparam int unsigned NARROW_WIDTH = 16;

   // Half and bfloat16 format constants
   localparam logic [14:0] HALF_INF     = 15'h7c00;
   localparam logic [14:0] HALF_MAX     = 15'h7bff;
   localparam logic [15:0] HALF_QUIET   = 16'h0200;
   localparam logic [15:0] BF16_QUIET   = 16'h0040;
   localparam logic [31:0] BF16_BIAS    = 32'h0000_7fff;

   // Single exponent thresholds for the half rebias (e16 = e32 - 112)
   localparam logic [7:0] EXP_BIAS_DIFF = 8'd112;  // e16 <= 0 at or below this
   localparam logic [7:0] EXP_HALF_OVF  = 8'd143;  // e16 >= 31 at or above this
   localparam logic [7:0] EXP_HALF_TINY = 8'd102;  // below this flushes to zero
   localparam logic [7:0] EXP_SUB_SHIFT = 8'd126;  // shift = 126 - e32
   localparam logic [7:0] EXP_SPECIAL   = 8'hff;

endpackage

/* hw/rtl/fthb_narrow.sv */
// Combinational narrowing of one binary32 word to half or bfloat16.
// Sits between the input and result registers of the top level.
// Depends on fthb_pkg.
module fthb_narrow (
   input  logic [fthb_pkg::FUNC_WIDTH-1:0]   func,
   input  logic [fthb_pkg::SINGLE_WIDTH-1:0] single_bits,
   output logic [fthb_pkg::NARROW_WIDTH-1:0] narrow_bits
);

   logic        sgn;
   logic [7:0]  e32;
   logic [22:0] mant;
   logic        mant_nz;
   logic        is_special;
   logic        is_ovf;
   logic        is_sub;
   logic        is_tiny;
   logic [7:0]  ex_full;
   logic [4:0]  ex16;
   logic [15:0] sign_word;

   // normal-range half rounding
   logic [15:0] norm_trunc;
   logic        norm_inc;
   logic [15:0] norm_round;

   // subnormal half rounding
   logic [7:0]  sh_full;
   logic [4:0]  sh;
   logic [4:0]  sh_m1;
   logic [23:0] fm;
   logic [23:0] sub_m;
   logic [23:0] fm_low;
   logic [23:0] sticky_mask;
   logic        round_bit;
   logic        sticky;
   logic        sub_inc;
   logic [15:0] sub_trunc;
   logic [15:0] sub_round;

   // bfloat16 rounding
   logic [31:0] bf_sum;
   logic [15:0] bf_round;

   logic [15:0] half_full;
   logic [15:0] half_trunc;
   logic [15:0] half_fast;
   logic [15:0] bf_full;

   // split fields and classify the exponent
   always_comb begin
      sgn        = single_bits[31];
      e32        = single_bits[30:23];
      mant       = single_bits[22:0];
      mant_nz    = (mant != 23'd0);
      is_special = (e32 == fthb_pkg::EXP_SPECIAL);
      is_ovf     = (e32 >= fthb_pkg::EXP_HALF_OVF);
      is_sub     = (e32 <= fthb_pkg::EXP_BIAS_DIFF);
      is_tiny    = (e32 < fthb_pkg::EXP_HALF_TINY);
      ex_full    = e32 - fthb_pkg::EXP_BIAS_DIFF;
      ex16       = ex_full[4:0];
      sign_word  = {sgn, 15'd0};
   end

   // round a normal-range half to nearest even
   always_comb begin
      norm_trunc = {sgn, ex16, mant[22:13]};
      norm_inc   = mant[12] & ((mant[11:0] != 12'd0) | mant[13]);
      norm_round = norm_trunc + {15'd0, norm_inc};
   end

   // denormalize into a half subnormal and round to nearest even
   always_comb begin
      sh_full     = fthb_pkg::EXP_SUB_SHIFT - e32;
      sh          = sh_full[4:0];
      sh_m1       = sh - 5'd1;
      fm          = {1'b1, mant};
      sub_m       = fm >> sh;
      fm_low      = fm >> sh_m1;
      round_bit   = fm_low[0];
      sticky_mask = (24'd1 << sh_m1) - 24'd1;
      sticky      = ((fm & sticky_mask) != 24'd0);
      sub_inc     = round_bit & (sticky | sub_m[0]);
      sub_trunc   = sign_word | {5'd0, sub_m[10:0]};
      sub_round   = sub_trunc + {15'd0, sub_inc};
   end

   // bfloat16 nearest even in a wrapping 32-bit adder
   always_comb begin
      bf_sum   = single_bits + fthb_pkg::BF16_BIAS + {31'd0, single_bits[16]};
      bf_round = bf_sum[31:16];
   end

   // assemble each operation's result
   always_comb begin
      if (is_special) begin
         half_full = sign_word | {1'b0, fthb_pkg::HALF_INF}
                     | (mant_nz ? fthb_pkg::HALF_QUIET : 16'd0);
      end else if (is_ovf) begin
         half_full = sign_word | {1'b0, fthb_pkg::HALF_INF};
      end else if (is_tiny) begin
         half_full = sign_word;
      end else if (is_sub) begin
         half_full = sub_round;
      end else begin
         half_full = norm_round;
      end

      if (is_special) begin
         half_trunc = sign_word | {1'b0, fthb_pkg::HALF_INF}
                      | (mant_nz ? fthb_pkg::HALF_QUIET : 16'd0);
      end else if (is_ovf) begin
         half_trunc = sign_word | {1'b0, fthb_pkg::HALF_MAX};
      end else if (is_tiny) begin
         half_trunc = sign_word;
      end else if (is_sub) begin
         half_trunc = sub_trunc;
      end else begin
         half_trunc = norm_trunc;
      end

      if (is_sub) begin
         half_fast = sign_word;
      end else if (is_ovf) begin
         half_fast = sign_word | {1'b0, fthb_pkg::HALF_INF};
      end else begin
         half_fast = norm_round;
      end

      if (is_special) begin
         bf_full = single_bits[31:16] | (mant_nz ? fthb_pkg::BF16_QUIET : 16'd0);
      end else begin
         bf_full = bf_round;
      end
   end

   // select by operation code
   always_comb begin
      case (fthb_pkg::func_type'(func))
         fthb_pkg::FUNC_RTNE_HALF: narrow_bits = half_full;
         fthb_pkg::FUNC_RTNE_BF16: narrow_bits = bf_full;
         fthb_pkg::FUNC_RTZ_HALF:  narrow_bits = half_trunc;
         fthb_pkg::FUNC_RTZ_BF16:  narrow_bits = single_bits[31:16];
         fthb_pkg::FUNC_FAST_HALF: narrow_bits = half_fast;
         fthb_pkg::FUNC_FAST_BF16: narrow_bits = bf_round;
         default:                  narrow_bits = 16'd0;
      endcase
   end

endmodule

/* hw/rtl/float32_to_half_bfloat_narrowing.sv */
// Top level of the binary32 to half / bfloat16 narrowing block.
// Registers the request word, narrows it in fthb_narrow, registers the result.
// Depends on fthb_pkg and fthb_narrow.
//
// Usage:
//   Request channel: drive req_func and req_single_bits and raise start. A word
//   is taken at every rising edge where start is high and busy is low. busy is
//   held low, so a new word may be issued in every cycle.
//   Result channel: rsp_strobe is high for exactly one cycle per word, with
//   rsp_narrow_bits valid in that cycle. Results leave in request order.
//   Each word passes the input register, then the result register.
//   Throughput: one word per cycle, set by the single conversion stage
//   between the two registers.
//   Reset: synchronous, active high; drops any word in flight and clears
//   the strobe. The data registers are not reset.
//   The receiver cannot stall; each result must be taken in its strobe cycle.
module float32_to_half_bfloat_narrowing (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [fthb_pkg::FUNC_WIDTH-1:0]     req_func,
   input  logic [fthb_pkg::SINGLE_WIDTH-1:0]   req_single_bits,
   output logic                                rsp_strobe,
   output logic [fthb_pkg::NARROW_WIDTH-1:0]   rsp_narrow_bits
);

   logic                                stage_valid_ff;
   logic                                stage_valid_in;
   logic [fthb_pkg::FUNC_WIDTH-1:0]     stage_func_ff;
   logic [fthb_pkg::SINGLE_WIDTH-1:0]   stage_bits_ff;
   logic                                rsp_valid_ff;
   logic [fthb_pkg::NARROW_WIDTH-1:0]   rsp_bits_ff;
   logic [fthb_pkg::NARROW_WIDTH-1:0]   rsp_bits_in;

   // never back-pressure the sender
   assign busy           = 1'b0;
   assign stage_valid_in = start & ~busy;

   // capture the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (stage_valid_in) begin
         stage_func_ff <= req_func;
         stage_bits_ff <= req_single_bits;
      end
   end

   // narrow the held word
   fthb_narrow u_narrow (
      .func        (stage_func_ff),
      .single_bits (stage_bits_ff),
      .narrow_bits (rsp_bits_in)
   );

   // advance into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_valid_ff;
      end
      if (stage_valid_ff) begin
         rsp_bits_ff <= rsp_bits_in;
      end
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_narrow_bits = rsp_bits_ff;

   // an accepted word shows up after the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted word did not produce a result");

   // no result without a matching earlier request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 2))
      else $error("result without request");

   // unused codes give a zero word
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_func, 2) > fthb_pkg::FUNC_FAST_BF16))
      |-> (rsp_narrow_bits == 16'd0))
      else $error("unused code gave a nonzero word");

   // bfloat16 truncation returns the upper half unchanged
   a_rtz_bf16: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_func, 2) == fthb_pkg::FUNC_RTZ_BF16)
      |-> (rsp_narrow_bits == $past(req_single_bits[31:16], 2)))
      else $error("bfloat16 truncation mismatch");

endmodule
